[rtl/msb_bit_field_reader_core_assert.svh]
// assertion macros for the msb bit field reader core
// used by the rtl modules that check their own invariants; no other dependencies
`ifndef MSB_BIT_FIELD_READER_CORE_ASSERT_SVH
`define MSB_BIT_FIELD_READER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// checked property, disabled while reset is asserted
`define MSBR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// checked property, also active during reset
`define MSBR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define MSBR_ASSERT(lbl, prop, msg)
`define MSBR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[rtl/msbr_pkg.sv]
// shared types and constants for the msb bit field reader core
// no dependencies; used by msbr_seq and msb_bit_field_reader_core
`default_nettype none

package msbr_pkg;

  // command codes carried in tuser
  typedef enum logic [3:0] {
    ACT_LOAD      = 4'd0,
    ACT_RD_BITS   = 4'd1,
    ACT_RD_SBITS  = 4'd2,
    ACT_RD_BYTES  = 4'd3,
    ACT_DROP      = 4'd4,
    ACT_TAG_BEGIN = 4'd5,
    ACT_TAG_FLUSH = 4'd6,
    ACT_SKIP      = 4'd7,
    ACT_CLEAR     = 4'd8
  } action_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_BUSY = 2'd1,
    ST_DONE = 2'd2
  } state_e;

  localparam int unsigned BYTE_BITS      = 8;
  localparam int unsigned MAX_BITS       = 32;
  localparam int unsigned MAX_READ_BYTES = 4;
  localparam logic [15:0] INDEX_MAX      = 16'hFFFF;

  // one command as unpacked from the input transfer
  typedef struct packed {
    logic [3:0]  action;
    logic [7:0]  byte_in;
    logic [5:0]  nbits;
    logic [15:0] count;
  } cmd_t;

  // one result before it is packed into the output transfer
  typedef struct packed {
    logic [31:0] value;
    logic        underflow;
    logic        end_seen;
    logic        tag_done;
    logic        load_dropped;
  } res_t;

endpackage

`default_nettype wire

[rtl/msbr_mem.sv]
// byte store of the msb bit field reader: one write port, one registered read port
// no package dependencies
`default_nettype none

module msbr_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port: data returns in the cycle after re_i
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/msbr_seq.sv]
// command sequencer of the msb bit field reader: reader state and fetch pipeline
// depends on msbr_pkg and msb_bit_field_reader_core_assert.svh; drives msbr_mem
`default_nettype none
`include "msb_bit_field_reader_core_assert.svh"

module msbr_seq #(
  parameter int unsigned BUFFER_BYTES = 4096,
  parameter int unsigned AW           = 12,
  parameter int unsigned FW           = 13
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  // command side
  input  wire logic          cmd_valid_i,
  output logic               cmd_ready_o,
  input  wire msbr_pkg::cmd_t cmd_i,
  // result side
  output logic               res_valid_o,
  input  wire logic          res_ready_i,
  output msbr_pkg::res_t     res_o,
  // byte store
  output logic               mem_we_o,
  output logic [AW-1:0]      mem_waddr_o,
  output logic [7:0]         mem_wdata_o,
  output logic               mem_re_o,
  output logic [AW-1:0]      mem_raddr_o,
  input  wire logic [7:0]    mem_rdata_i
);

  function automatic logic [7:0] mask8(input logic [2:0] k);
    mask8 = 8'((9'd1 << k) - 9'd1);
  endfunction

  function automatic logic [31:0] mask32(input logic [5:0] k);
    mask32 = 32'((33'd1 << k) - 33'd1);
  endfunction

  msbr_pkg::state_e state_q, state_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [15:0]   ridx_q, ridx_d;
  logic [7:0]    lbits_q, lbits_d;
  logic [2:0]    lcnt_q, lcnt_d;
  logic [15:0]   tag_q, tag_d;
  logic          end_q, end_d;
  logic          unf_q, unf_d;
  logic          drop_q, drop_d;
  logic [31:0]   acc_q, acc_d;
  logic [3:0]    act_q, act_d;
  logic [5:0]    nbits_q, nbits_d;
  logic [2:0]    iss_q, iss_d;
  logic [2:0]    part_q, part_d;
  logic [1:0]    bpos_q, bpos_d;
  logic          pend_q, pend_d;
  logic          pend_ok_q, pend_ok_d;
  logic          pend_last_q, pend_last_d;

  // command decode helpers
  logic [5:0]  nb;
  logic [2:0]  t0;
  logic [2:0]  new_lc;
  logic [5:0]  rem;
  logic [5:0]  rem_up;
  logic [2:0]  nfetch;
  logic [15:0] skip_n;
  logic [16:0] skip_sum;
  logic        fetch_ok;
  logic [7:0]  fbyte;
  logic [2:0]  keep;
  logic        sign_bit;

  assign nb       = (cmd_i.nbits > 6'(msbr_pkg::MAX_BITS)) ? 6'(msbr_pkg::MAX_BITS)
                                                            : cmd_i.nbits;
  assign t0       = (nb < {3'b000, lcnt_q}) ? nb[2:0] : lcnt_q;
  assign new_lc   = lcnt_q - t0;
  assign rem      = nb - {3'b000, t0};
  assign rem_up   = rem + 6'd7;
  assign nfetch   = rem_up[5:3];
  assign skip_n   = (msbr_pkg::action_e'(cmd_i.action) == msbr_pkg::ACT_TAG_FLUSH) ? tag_q
                                                                                   : cmd_i.count;
  assign skip_sum = {1'b0, ridx_q} + {1'b0, skip_n};
  assign fetch_ok = ({1'b0, ridx_q} < 17'(fill_q)) && (ridx_q != msbr_pkg::INDEX_MAX);
  assign fbyte    = pend_ok_q ? mem_rdata_i : 8'h00;
  assign keep     = 3'(4'd8 - {1'b0, part_q});

  // next state and datapath
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    ridx_d      = ridx_q;
    lbits_d     = lbits_q;
    lcnt_d      = lcnt_q;
    tag_d       = tag_q;
    end_d       = end_q;
    unf_d       = unf_q;
    drop_d      = drop_q;
    acc_d       = acc_q;
    act_d       = act_q;
    nbits_d     = nbits_q;
    iss_d       = iss_q;
    part_d      = part_q;
    bpos_d      = bpos_q;
    pend_d      = 1'b0;
    pend_ok_d   = pend_ok_q;
    pend_last_d = pend_last_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = fill_q[AW-1:0];
    mem_wdata_o = cmd_i.byte_in;
    mem_re_o    = 1'b0;
    mem_raddr_o = ridx_q[AW-1:0];

    case (state_q)
      msbr_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          act_d   = cmd_i.action;
          nbits_d = nb;
          acc_d   = '0;
          unf_d   = 1'b0;
          drop_d  = 1'b0;
          bpos_d  = '0;
          part_d  = '0;
          state_d = msbr_pkg::ST_DONE;
          case (msbr_pkg::action_e'(cmd_i.action))
            msbr_pkg::ACT_LOAD: begin
              if (fill_q < FW'(BUFFER_BYTES)) begin
                mem_we_o = 1'b1;
                fill_d   = fill_q + FW'(1);
              end else begin
                drop_d = 1'b1;
              end
            end
            msbr_pkg::ACT_RD_BITS, msbr_pkg::ACT_RD_SBITS: begin
              // leftover bits go first, then whole or partial bytes
              acc_d   = {24'h0, lbits_q >> new_lc};
              lcnt_d  = new_lc;
              lbits_d = lbits_q & mask8(new_lc);
              iss_d   = nfetch;
              part_d  = rem[2:0];
              if (nfetch != 3'd0) begin
                state_d = msbr_pkg::ST_BUSY;
              end
            end
            msbr_pkg::ACT_RD_BYTES: begin
              iss_d = (cmd_i.count > 16'(msbr_pkg::MAX_READ_BYTES))
                      ? 3'(msbr_pkg::MAX_READ_BYTES) : cmd_i.count[2:0];
              if (cmd_i.count != 16'd0) begin
                state_d = msbr_pkg::ST_BUSY;
              end
            end
            msbr_pkg::ACT_DROP: begin
              lcnt_d  = '0;
              lbits_d = '0;
            end
            msbr_pkg::ACT_TAG_BEGIN: begin
              tag_d = cmd_i.count;
            end
            msbr_pkg::ACT_TAG_FLUSH, msbr_pkg::ACT_SKIP: begin
              ridx_d = skip_sum[16] ? msbr_pkg::INDEX_MAX : skip_sum[15:0];
              tag_d  = (skip_n >= tag_q) ? 16'd0 : tag_q - skip_n;
            end
            msbr_pkg::ACT_CLEAR: begin
              fill_d = '0;
              ridx_d = '0;
            end
            default: begin
            end
          endcase
        end
      end

      msbr_pkg::ST_BUSY: begin
        // issue side: one byte fetch per cycle
        if (iss_q != 3'd0) begin
          if (fetch_ok) begin
            mem_re_o = 1'b1;
            ridx_d   = ridx_q + 16'd1;
            if (tag_q != 16'd0) begin
              tag_d = tag_q - 16'd1;
            end
          end else begin
            end_d = 1'b1;
            unf_d = 1'b1;
          end
          pend_d      = 1'b1;
          pend_ok_d   = fetch_ok;
          pend_last_d = (iss_q == 3'd1);
          iss_d       = iss_q - 3'd1;
        end
        // return side: merge the byte whose read was issued in the previous cycle
        if (pend_q) begin
          if (msbr_pkg::action_e'(act_q) == msbr_pkg::ACT_RD_BYTES) begin
            acc_d  = acc_q | (32'(fbyte) << {bpos_q, 3'b000});
            bpos_d = bpos_q + 2'd1;
          end else if (pend_last_q && (part_q != 3'd0)) begin
            acc_d   = (acc_q << part_q) | 32'(fbyte >> keep);
            lcnt_d  = keep;
            lbits_d = fbyte & mask8(keep);
          end else begin
            acc_d = {acc_q[23:0], fbyte};
          end
          if (pend_last_q) begin
            state_d = msbr_pkg::ST_DONE;
          end
        end
      end

      msbr_pkg::ST_DONE: begin
        if (res_ready_i) begin
          state_d = msbr_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = msbr_pkg::ST_IDLE;
      end
    endcase
  end

  // control and reader state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= msbr_pkg::ST_IDLE;
      fill_q    <= '0;
      ridx_q    <= '0;
      lbits_q   <= '0;
      lcnt_q    <= '0;
      tag_q     <= '0;
      end_q     <= 1'b0;
      iss_q     <= '0;
      pend_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      ridx_q    <= ridx_d;
      lbits_q   <= lbits_d;
      lcnt_q    <= lcnt_d;
      tag_q     <= tag_d;
      end_q     <= end_d;
      iss_q     <= iss_d;
      pend_q    <= pend_d;
    end
  end

  // per-command working registers
  always_ff @(posedge clk_i) begin
    unf_q       <= unf_d;
    drop_q      <= drop_d;
    acc_q       <= acc_d;
    act_q       <= act_d;
    nbits_q     <= nbits_d;
    part_q      <= part_d;
    bpos_q      <= bpos_d;
    pend_ok_q   <= pend_ok_d;
    pend_last_q <= pend_last_d;
  end

  // result, with sign extension of signed bit reads
  assign sign_bit = acc_q[5'(nbits_q - 6'd1)];

  always_comb begin
    res_o.value = acc_q;
    if ((msbr_pkg::action_e'(act_q) == msbr_pkg::ACT_RD_SBITS) && (nbits_q != 6'd0) &&
        (nbits_q < 6'(msbr_pkg::MAX_BITS)) && sign_bit) begin
      res_o.value = acc_q | ~mask32(nbits_q);
    end
    res_o.underflow    = unf_q;
    res_o.end_seen     = end_q;
    res_o.tag_done     = (tag_q == 16'd0);
    res_o.load_dropped = drop_q;
  end

  assign cmd_ready_o = (state_q == msbr_pkg::ST_IDLE);
  assign res_valid_o = (state_q == msbr_pkg::ST_DONE);

  // invariants
  `MSBR_ASSERT(a_fill_bound, fill_q <= FW'(BUFFER_BYTES), "fill count above buffer size")
  `MSBR_ASSERT(a_leftover_clean, (lbits_q >> lcnt_q) == 8'h00, "stale bits above leftover count")
  `MSBR_ASSERT(a_pend_from_busy, pend_q |-> $past(state_q) == msbr_pkg::ST_BUSY, "fetch return outside busy")
  `MSBR_ASSERT(a_index_step, (state_q == msbr_pkg::ST_BUSY) |=> (ridx_q == $past(ridx_q)) || (ridx_q == $past(ridx_q) + 16'd1), "read index jumped during fetch")

endmodule

`default_nettype wire

[rtl/msb_bit_field_reader_core.sv]
// msb bit field reader: a byte buffer served by an msb-first bit reader and a
// little-endian byte reader, over one command stream and one result stream.
// Each command transfer carries the action code in s_axis_tuser and its operands in
// s_axis_tdata; every command returns exactly one result transfer on m_axis.
// Loads, skips, tag commands, drop, clear, bit reads served from the leftover alone
// and reads of zero length go from accept straight to the result state.
// A bit read that fetches reads ceil(r / 8) bytes, r being the bits left after the
// leftover of the last byte; a byte read of k > 0 bytes reads min(k, 4) bytes. The byte
// store has one registered read port, so fetches run at one byte per cycle: a 32-bit
// read that starts on a byte boundary fetches four bytes, as does a 4-byte read.
// One command is in flight at a time; the next is accepted once the result is placed
// in the output register, and a held result does not block the next command.
// Reset empties the buffer and clears the read index, leftover bits, tag counter and
// end flag; store contents stay undefined until loaded and need no clearing pass.
// When the receiver holds m_axis_tready low, the output register keeps its result,
// the sequencer waits with the next result, and s_axis_tready then stays low.
// depends on msbr_pkg, msbr_mem and msbr_seq
`default_nettype none

module msb_bit_field_reader_core #(
  parameter int unsigned BUFFER_BYTES = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // command stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // byte_in[7:0], nbits[13:8], count[29:14], zero[31:30]
  input  wire logic [3:0]  s_axis_tuser,  // action[3:0]
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata   // value[31:0], underflow[32], end_seen[33],
                                          // tag_done[34], load_dropped[35], zero[39:36]
);

  localparam int unsigned AW = $clog2(BUFFER_BYTES);
  localparam int unsigned FW = $clog2(BUFFER_BYTES + 1);

  msbr_pkg::cmd_t cmd;
  msbr_pkg::res_t res;
  logic           res_valid;
  logic           res_ready;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [7:0]     mem_wdata;
  logic           mem_re;
  logic [AW-1:0]  mem_raddr;
  logic [7:0]     mem_rdata;
  logic           out_valid_q;
  logic [39:0]    out_data_q;

  // unpack the command transfer
  assign cmd.action  = s_axis_tuser;
  assign cmd.byte_in = s_axis_tdata[7:0];
  assign cmd.nbits   = s_axis_tdata[13:8];
  assign cmd.count   = s_axis_tdata[29:14];

  msbr_mem #(
    .DEPTH (BUFFER_BYTES),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  msbr_seq #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .AW           (AW),
    .FW           (FW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (s_axis_tvalid),
    .cmd_ready_o (s_axis_tready),
    .cmd_i       (cmd),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // output register decouples the sequencer from the receiver
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= {4'h0, res.load_dropped, res.tag_done, res.end_seen, res.underflow,
                     res.value};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire
